[hdl/tcg_pkg.sv]
// package for the text cell glyph row to rgb565 expander
// holds request types, colour depth codes and row constants; no dependencies
package tcg_pkg;

    localparam int PIXELS = 8;
    localparam int CNT_W  = $clog2(PIXELS);

    typedef enum logic [1:0] {
        DEPTH_IRGB   = 2'd0,
        DEPTH_BYTE   = 2'd1,
        DEPTH_DIRECT = 2'd2,
        DEPTH_MONO   = 2'd3
    } depth_t;

    localparam logic [15:0] GREY_RGB565 = 16'h528A;
    localparam logic [3:0]  GREY_NIBBLE = 4'h8;

    typedef struct packed {
        logic [7:0]  glyph_row;
        logic [15:0] bg_code;
        logic [15:0] fg_code;
    } tcg_in_t;

    typedef struct packed {
        logic [15:0] pixel;
        logic        last_pixel;
    } tcg_out_t;

    typedef struct packed {
        logic [PIXELS-1:0] row;
        logic [15:0]       bg;
        logic [15:0]       fg;
    } tcg_row_t;

endpackage

[hdl/tcg_colour.sv]
// colour code to rgb565 conversion for one code
// depends on tcg_pkg
module tcg_colour
    import tcg_pkg::*;
(
    input  depth_t      depth,
    input  logic        is_fg,
    input  logic [15:0] code,
    output logic [15:0] rgb
);

    logic [3:0]  nib;
    logic [7:0]  byt;
    logic [1:0]  lvl;
    logic [15:0] nib_rgb;
    logic [16:0] byt_sum;

    assign nib = code[3:0];
    assign byt = code[7:0];
    assign lvl = byt[7:6];

    always_comb begin
        nib_rgb = 16'h0000;
        if (nib == GREY_NIBBLE) begin
            nib_rgb = GREY_RGB565;
        end else begin
            if (nib[2]) begin
                nib_rgb = nib_rgb + 16'h7800 + (nib[3] ? 16'h8000 : 16'h0000);
            end
            if (nib[1]) begin
                nib_rgb = nib_rgb + 16'h03E0 + (nib[3] ? 16'h0400 : 16'h0000);
            end
            if (nib[0]) begin
                nib_rgb = nib_rgb + 16'h000F + (nib[3] ? 16'h0010 : 16'h0000);
            end
        end
    end

    always_comb begin
        byt_sum = 17'd0;
        if (byt[5:4] != 2'b00) begin
            byt_sum = byt_sum + (byt[5] ? 17'h02000 : 17'h0)
                              + (byt[4] ? 17'h01800 : 17'h0)
                              + {1'b0, lvl, 14'd0};
        end
        if (byt[3:2] != 2'b00) begin
            byt_sum = byt_sum + (byt[3] ? 17'h00180 : 17'h0)
                              + (byt[2] ? 17'h00060 : 17'h0)
                              + {5'd0, lvl, 10'd0};
        end
        if (byt[1:0] != 2'b00) begin
            byt_sum = byt_sum + (byt[1] ? 17'h00004 : 17'h0)
                              + (byt[0] ? 17'h00003 : 17'h0)
                              + {12'd0, lvl, 3'd0};
        end
    end

    always_comb begin
        unique case (depth)
            DEPTH_IRGB:   rgb = nib_rgb;
            DEPTH_BYTE:   rgb = byt_sum[15:0];
            DEPTH_DIRECT: rgb = code;
            DEPTH_MONO:   rgb = is_fg ? 16'hFFFF : 16'h0000;
            default:      rgb = 16'h0000;
        endcase
    end

endmodule

[hdl/tcg_serializer.sv]
// emits one rgb565 pixel per cycle while m_ready is high, from a converted glyph row
// depends on tcg_pkg
module tcg_serializer
    import tcg_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     load_valid,
    output logic     load_ready,
    input  tcg_row_t load_data,
    output logic     m_valid,
    input  logic     m_ready,
    output tcg_out_t m_data
);

    logic              busy_reg;
    logic              busy_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [PIXELS-1:0] row_reg;
    logic [PIXELS-1:0] row_next;
    logic [15:0]       fg_reg;
    logic [15:0]       bg_reg;
    logic              last;
    logic              take;
    logic              load;

    assign last       = (cnt_reg == CNT_W'(PIXELS - 1));
    assign take       = busy_reg && m_ready;
    assign load_ready = !busy_reg || (take && last);
    assign load       = load_valid && load_ready;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        row_next  = row_reg;
        if (load) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            row_next  = load_data.row;
        end else if (take) begin
            busy_next = !last;
            cnt_next  = cnt_reg + 1'b1;
            row_next  = {row_reg[PIXELS-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg <= row_next;
        if (load) begin
            fg_reg <= load_data.fg;
            bg_reg <= load_data.bg;
        end
    end

    assign m_valid           = busy_reg;
    assign m_data.pixel      = row_reg[PIXELS-1] ? fg_reg : bg_reg;
    assign m_data.last_pixel = last;

endmodule

[hdl/text_cell_glyph_row_to_rgb565_top.sv]
// top level of the text cell glyph row to rgb565 expander
// depends on tcg_pkg, tcg_colour and tcg_serializer
//
// usage:
//   s_ channel takes one request per text cell row: glyph row byte plus
//   background and foreground colour codes. m_ channel returns eight rgb565
//   pixels for it, glyph bit 7 first, the eighth flagged with last_pixel.
//   cfg_wr_en / cfg_wr_data set the colour depth (0 irgb nibble, 1 byte
//   code, 2 direct rgb565, 3 mono white on black); write it only while idle.
//   an accepted request is converted and registered in the hold register,
//   then loads into the serializer once that is free. the single pixel
//   output sends one pixel per cycle while m_ready is high. the hold
//   register takes the next row while the current one is still going out,
//   so rows follow without a gap. a stall on m_ready freezes the current
//   pixel; s_ready drops while the hold register is full and the serializer
//   cannot take it. reset clears both stages and sets depth to 0.
module text_cell_glyph_row_to_rgb565_top
    import tcg_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  tcg_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output tcg_out_t   m_data,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data
);

    depth_t      depth_reg;
    logic        hold_valid_reg;
    tcg_row_t    hold_reg;
    logic [15:0] bg_rgb;
    logic [15:0] fg_rgb;
    logic        ser_ready;
    logic        s_take;

    tcg_colour u_bg_colour (
        .depth (depth_reg),
        .is_fg (1'b0),
        .code  (s_data.bg_code),
        .rgb   (bg_rgb)
    );

    tcg_colour u_fg_colour (
        .depth (depth_reg),
        .is_fg (1'b1),
        .code  (s_data.fg_code),
        .rgb   (fg_rgb)
    );

    assign s_ready = !hold_valid_reg || ser_ready;
    assign s_take  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg      <= DEPTH_IRGB;
            hold_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                depth_reg <= depth_t'(cfg_wr_data);
            end
            if (s_take) begin
                hold_valid_reg <= 1'b1;
            end else if (ser_ready) begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            hold_reg.row <= s_data.glyph_row;
            hold_reg.bg  <= bg_rgb;
            hold_reg.fg  <= fg_rgb;
        end
    end

    tcg_serializer u_serializer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (hold_valid_reg),
        .load_ready (ser_ready),
        .load_data  (hold_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // pixels of one row go out without a hole
    a_row_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.last_pixel) |=> m_valid)
        else $error("row output broke before last pixel");

    // a held row waits until the serializer takes it
    a_hold_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (hold_valid_reg && !ser_ready) |=> hold_valid_reg)
        else $error("held row dropped");

    // no accept while hold is full and serializer busy
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (hold_valid_reg && !ser_ready) |-> !s_ready)
        else $error("hold register overrun");

    a_reset_empty: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> (!m_valid && !hold_valid_reg))
        else $error("pipeline not empty after reset");

endmodule

[tb/text_cell_glyph_row_to_rgb565_top_test.sv]
// self-checking bench for text_cell_glyph_row_to_rgb565_top: a directed table, then random rows
// at randomly chosen colour depths, with each pixel checked against table colours or a colour expansion predictor
// depends on tcg_pkg and the expander rtl
module text_cell_glyph_row_to_rgb565_top_test
    import tcg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        depth_t      depth;
        logic [7:0]  glyph;
        logic [15:0] bg;
        logic [15:0] fg;
        logic        typed;
        logic [15:0] exp_bg;
        logic [15:0] exp_fg;
    } cell_case_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    tcg_in_t    s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    tcg_out_t   m_data;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_wr_data = '0;

    // colours typed into the table travel with the request
    logic        row_typed = 1'b0;
    logic [15:0] typed_bg = '0;
    logic [15:0] typed_fg = '0;

    tcg_out_t pending_pixels[$];
    depth_t   shadow_depth = DEPTH_IRGB;
    depth_t   cur_depth = DEPTH_IRGB;
    int       mismatches = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       holds_wanted = 0;
    int       holds_done = 0;

    cell_case_t cell_cases [18] = '{
        '{DEPTH_IRGB,   8'h00, 16'h0000, 16'h000F, 1'b1, 16'h0000, 16'hFFFF},
        '{DEPTH_IRGB,   8'hFF, 16'hFFF8, 16'h0008, 1'b1, 16'h528A, 16'h528A},
        '{DEPTH_IRGB,   8'h80, 16'h0001, 16'h0004, 1'b1, 16'h000F, 16'h7800},
        '{DEPTH_IRGB,   8'h01, 16'h0002, 16'h000C, 1'b1, 16'h03E0, 16'hF800},
        '{DEPTH_IRGB,   8'hA5, 16'h0007, 16'h0009, 1'b0, 16'h0000, 16'h0000},
        '{DEPTH_IRGB,   8'h5A, 16'hF00E, 16'h0F0B, 1'b0, 16'h0000, 16'h0000},
        '{DEPTH_BYTE,   8'hF0, 16'h0000, 16'h00FF, 1'b0, 16'h0000, 16'h0000},
        '{DEPTH_BYTE,   8'h0F, 16'h00C0, 16'h003F, 1'b0, 16'h0000, 16'h0000},
        '{DEPTH_BYTE,   8'h7E, 16'hFF00, 16'h0020, 1'b1, 16'h0000, 16'h2000},
        '{DEPTH_BYTE,   8'h3C, 16'h0055, 16'hFFAA, 1'b0, 16'h0000, 16'h0000},
        '{DEPTH_BYTE,   8'hC3, 16'h0081, 16'h004C, 1'b0, 16'h0000, 16'h0000},
        '{DEPTH_DIRECT, 8'h00, 16'hFFFF, 16'h0000, 1'b1, 16'hFFFF, 16'h0000},
        '{DEPTH_DIRECT, 8'hFF, 16'h0000, 16'hFFFF, 1'b1, 16'h0000, 16'hFFFF},
        '{DEPTH_DIRECT, 8'h96, 16'h8000, 16'h0001, 1'b1, 16'h8000, 16'h0001},
        '{DEPTH_DIRECT, 8'h69, 16'h1234, 16'hFEDC, 1'b0, 16'h0000, 16'h0000},
        '{DEPTH_MONO,   8'hAA, 16'h1234, 16'h5678, 1'b1, 16'h0000, 16'hFFFF},
        '{DEPTH_MONO,   8'h55, 16'hFFFF, 16'h0000, 1'b1, 16'h0000, 16'hFFFF},
        '{DEPTH_IRGB,   8'h81, 16'h0003, 16'h000D, 1'b0, 16'h0000, 16'h0000}
    };

    text_cell_glyph_row_to_rgb565_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [15:0] code_to_rgb565(depth_t depth, logic [15:0] code, bit is_fg);
        logic [3:0]  nib;
        logic [7:0]  b;
        logic [1:0]  lvl;
        logic [15:0] c;
        c = '0;
        nib = code[3:0];
        b = code[7:0];
        lvl = b[7:6];
        case (depth)
            DEPTH_IRGB: begin
                if (nib == GREY_NIBBLE) begin
                    c = GREY_RGB565;
                end else begin
                    if (nib[2]) c += 16'h7800 + (nib[3] ? 16'h8000 : 16'h0000);
                    if (nib[1]) c += 16'h03E0 + (nib[3] ? 16'h0400 : 16'h0000);
                    if (nib[0]) c += 16'h000F + (nib[3] ? 16'h0010 : 16'h0000);
                end
            end
            DEPTH_BYTE: begin
                if (b[5:4] != 2'b00)
                    c += (b[5] ? 16'h2000 : 16'h0000) + (b[4] ? 16'h1800 : 16'h0000)
                         + {lvl, 14'd0};
                if (b[3:2] != 2'b00)
                    c += (b[3] ? 16'h0180 : 16'h0000) + (b[2] ? 16'h0060 : 16'h0000)
                         + {4'd0, lvl, 10'd0};
                if (b[1:0] != 2'b00)
                    c += (b[1] ? 16'h0004 : 16'h0000) + (b[0] ? 16'h0003 : 16'h0000)
                         + {11'd0, lvl, 3'd0};
            end
            DEPTH_DIRECT: c = code;
            default: c = is_fg ? 16'hFFFF : 16'h0000;
        endcase
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // request acceptance, pixel checking and the depth shadow
    always @(posedge aclk) begin
        logic [15:0] bg_px;
        logic [15:0] fg_px;
        tcg_out_t    want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                bg_px = row_typed ? typed_bg : code_to_rgb565(shadow_depth, s_data.bg_code, 1'b0);
                fg_px = row_typed ? typed_fg : code_to_rgb565(shadow_depth, s_data.fg_code, 1'b1);
                for (int k = 0; k < PIXELS; k++) begin
                    want.pixel = s_data.glyph_row[PIXELS-1-k] ? fg_px : bg_px;
                    want.last_pixel = (k == PIXELS - 1);
                    pending_pixels.push_back(want);
                end
            end
            if (m_valid && m_ready) begin
                if (pending_pixels.size() == 0) begin
                    report_mismatch("unexpected pixel", m_data.pixel, 16'h0000);
                end else begin
                    want = pending_pixels.pop_front();
                    if (m_data.pixel !== want.pixel)
                        report_mismatch("pixel", m_data.pixel, want.pixel);
                    if (m_data.last_pixel !== want.last_pixel)
                        report_mismatch("last_pixel", {15'd0, m_data.last_pixel},
                                        {15'd0, want.last_pixel});
                end
            end
            if (cfg_wr_en)
                shadow_depth = depth_t'(cfg_wr_data);
        end
    end

    // pixel receiver with random back-pressure and long hold-offs on demand
    initial begin
        forever begin
            @(negedge aclk);
            if (holds_wanted != holds_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                holds_done++;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // entered and left just after a falling edge
    task automatic send_row(input tcg_in_t row, input logic typed,
                            input logic [15:0] tbg, input logic [15:0] tfg);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_data    <= row;
        row_typed <= typed;
        typed_bg  <= tbg;
        typed_fg  <= tfg;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_all_pixels();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_pixels.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_depth(input depth_t depth);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= depth;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_depth = depth;
        @(negedge aclk);
    endtask

    function automatic logic [15:0] random_code();
        logic [15:0] code;
        code = 16'($urandom);
        if ($urandom_range(7) == 0)
            code[3:0] = GREY_NIBBLE;
        return code;
    endfunction

    task automatic send_random_rows(input int count);
        tcg_in_t row;
        for (int i = 0; i < count; i++) begin
            row.glyph_row = 8'($urandom_range(255));
            row.bg_code   = random_code();
            row.fg_code   = random_code();
            send_row(row, 1'b0, 16'h0000, 16'h0000);
        end
    endtask

    task automatic run_phase(input int count, input int s_idle, input int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int i = 0; i < count; i += 25) begin
            wait_all_pixels();
            write_depth(depth_t'($urandom_range(3)));
            send_random_rows((count - i < 25) ? count - i : 25);
        end
    endtask

    initial begin
        tcg_in_t row;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 20;
        recv_idle_pct = 20;
        foreach (cell_cases[i]) begin
            if (cell_cases[i].depth != cur_depth) begin
                wait_all_pixels();
                write_depth(cell_cases[i].depth);
            end
            row.glyph_row = cell_cases[i].glyph;
            row.bg_code   = cell_cases[i].bg;
            row.fg_code   = cell_cases[i].fg;
            send_row(row, cell_cases[i].typed, cell_cases[i].exp_bg, cell_cases[i].exp_fg);
        end

        run_phase(100, 31, 74);
        run_phase(100, 74, 31);

        // receiver holds off while the sender keeps pushing rows
        wait_all_pixels();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        holds_wanted <= holds_wanted + 1;
        send_random_rows(24);
        run_phase(76, 0, 0);

        wait_all_pixels();
        repeat (16) @(negedge aclk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("timeout with %0d pixels outstanding", pending_pixels.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
hdl/tcg_pkg.sv
hdl/tcg_colour.sv
hdl/tcg_serializer.sv
hdl/text_cell_glyph_row_to_rgb565_top.sv
tb/text_cell_glyph_row_to_rgb565_top_test.sv
